// ===== design/aes128_cipher_with_fault_injection_assert.svh =====
// Assertion macros for the AES-128 block
`ifndef AES128_CIPHER_WITH_FAULT_INJECTION_ASSERT_SVH
`define AES128_CIPHER_WITH_FAULT_INJECTION_ASSERT_SVH
// implication checked every clock, off during reset
`define AES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/aes_pkg.sv =====
// ---------------------------------------------------------------------------
// AES package
// S-boxes, round constant and byte-level helpers for the cipher pipeline.
// ---------------------------------------------------------------------------
package aes_pkg;

  // key register indexes on the cfg channel
  localparam logic KEY_HIGH_IDX = 1'b0;
  localparam logic KEY_LOW_IDX  = 1'b1;

  typedef logic [127:0] block_t;
  typedef logic [7:0]   byte_t;

  typedef enum logic [0:0] {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_EARLY = 2'd1,
    FAULT_LATE  = 2'd2,
    FAULT_RSVD  = 2'd3
  } fault_t;

  typedef struct packed {
    logic   dec;
    fault_t mode;
    byte_t  fval;
  } ctrl_t;

  localparam byte_t [0:255] SBOX_FWD = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam byte_t [0:255] SBOX_INV = {
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  localparam byte_t [0:9] RCON = {
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  function automatic byte_t get_byte(block_t b, int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic byte_t xtime(byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(block_t k, byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {SBOX_FWD[w3[23:16]] ^ rc, SBOX_FWD[w3[15:8]], SBOX_FWD[w3[7:0]],
         SBOX_FWD[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== design/aes_stream_if.sv =====
// ---------------------------------------------------------------------------
// AES stream interfaces
// Valid/ready channels for blocks, results and key writes.
// ---------------------------------------------------------------------------
interface aes_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic [1:0]  fault_mode;
  logic [7:0]  fault_value;
  modport source (output valid, cmd, block_high, block_low, fault_mode, fault_value,
                  input ready);
  modport sink (input valid, cmd, block_high, block_low, fault_mode, fault_value,
                output ready);
endinterface

interface aes_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/aes_round.sv =====
// ---------------------------------------------------------------------------
// AES round
// One encryption or decryption round (straight inverse-cipher order for decrypt) on a block.
// ---------------------------------------------------------------------------
module aes_round (
  input  aes_pkg::block_t s,
  input  aes_pkg::block_t rk,
  input  logic            dec,
  input  logic            do_mix,
  output aes_pkg::block_t y
);
  aes_pkg::block_t sb, sr, mc, imc;

  always_comb begin
    aes_pkg::byte_t a0, a1, a2, a3, all, u, v;
    sb = '0; sr = '0; mc = '0; imc = '0;
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; all = '0; u = '0; v = '0;
    // decrypt: ShiftRows inverse, SubBytes inverse, AddKey, InvMix
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) begin
          sr[127 - 8*(4*c+r) -: 8] = aes_pkg::get_byte(s, ((c + 4 - r) % 4)*4 + r);
        end else begin
          sr[127 - 8*(4*c+r) -: 8] = aes_pkg::SBOX_FWD[aes_pkg::get_byte(s, ((c + r) % 4)*4 + r)];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[127 - 8*i -: 8] = dec ? aes_pkg::SBOX_INV[sr[127 - 8*i -: 8]] : sr[127 - 8*i -: 8];
    end
    if (dec) begin
      sb = sb ^ rk;
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[127 - 32*c -: 8]; a1 = sb[119 - 32*c -: 8];
      a2 = sb[111 - 32*c -: 8]; a3 = sb[103 - 32*c -: 8];
      if (dec) begin
        u = aes_pkg::xtime(aes_pkg::xtime(a0 ^ a2));
        v = aes_pkg::xtime(aes_pkg::xtime(a1 ^ a3));
        a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
      end
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32*c -: 32] = {a0 ^ all ^ aes_pkg::xtime(a0 ^ a1),
                              a1 ^ all ^ aes_pkg::xtime(a1 ^ a2),
                              a2 ^ all ^ aes_pkg::xtime(a2 ^ a3),
                              a3 ^ all ^ aes_pkg::xtime(a3 ^ a0)};
    end
    imc = do_mix ? mc : sb;
    y = dec ? imc : (imc ^ rk);
  end
endmodule

// ===== design/aes128_cipher_with_fault_injection.sv =====
// ---------------------------------------------------------------------------
// AES-128 cipher with fault injection
// Unrolled eleven-stage AES-128 pipeline, encrypt and decrypt per request.
// ---------------------------------------------------------------------------
// Channels: blk_in carries one request (cmd, block, fault mode and byte);
// res_out returns one result block per request, in order. cfg writes the key:
// index 0 key bytes 0..7, index 1 bytes 8..15; ready is always high.
// Key schedule: the eleven round keys are expanded from the key registers one
// round per cycle into a key register file; after reset and after each key
// write the block takes no requests while the expansion runs.
// Pipeline: stage 0 adds round key 0 or 10 at the accepting edge, stages
// 1..10 each do one round, and the result leaves stage 10. Throughput: one
// request per cycle while neither a stall nor the key expansion holds it.
// Stall: the whole pipeline advances only when its last stage is empty or is
// being taken, so a stalled receiver holds every stage and loses nothing;
// blk_in.ready drops in the same cycle.
// Faults: encrypt only, byte 0 of the state is XORed with fault_value before
// round 8 (mode 1) or round 9 (mode 2). Mode 3 acts as mode 0.
// Reset: clears all valid bits and the key registers, then runs the schedule.
module aes128_cipher_with_fault_injection #(
  parameter int unsigned NUM_ROUNDS = 10
) (
  input logic clk,
  input logic rst,
  aes_in_if.sink    blk_in,
  aes_out_if.source res_out,
  aes_cfg_if.sink   cfg
);
  localparam int unsigned RW = $clog2(NUM_ROUNDS + 1);

  logic [63:0]     key_high, key_low;
  aes_pkg::block_t rkey [NUM_ROUNDS+1];
  aes_pkg::block_t kcur;
  logic [RW-1:0]   kcnt;
  logic            kbusy;

  // key schedule sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      kbusy    <= 1'b1;
      kcnt     <= '0;
      kcur     <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == aes_pkg::KEY_LOW_IDX) key_low <= cfg.data;
      else                                   key_high <= cfg.data;
      kbusy <= 1'b1;
      kcnt  <= '0;
      kcur  <= (cfg.index == aes_pkg::KEY_LOW_IDX) ? {key_high, cfg.data}
                                                   : {cfg.data, key_low};
    end else if (kbusy) begin
      rkey[kcnt] <= kcur;
      kcur <= aes_pkg::next_key(kcur, aes_pkg::RCON[kcnt[3:0]]);
      if (kcnt == RW'(NUM_ROUNDS)) kbusy <= 1'b0;
      kcnt <= kcnt + 1'b1;
    end
  end
  assign cfg.ready = 1'b1;

  // pipeline
  aes_pkg::block_t st   [NUM_ROUNDS+1];
  aes_pkg::ctrl_t  ctl  [NUM_ROUNDS+1];
  logic            vld  [NUM_ROUNDS+1];
  logic            adv;

  assign adv = !vld[NUM_ROUNDS] || res_out.ready;
  assign blk_in.ready = adv && !kbusy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_ROUNDS; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= blk_in.valid && !kbusy;
      for (int i = 1; i <= NUM_ROUNDS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= '{dec: blk_in.cmd, mode: aes_pkg::fault_t'(blk_in.fault_mode),
                  fval: blk_in.fault_value};
      st[0]  <= {blk_in.block_high, blk_in.block_low} ^
                (blk_in.cmd ? rkey[NUM_ROUNDS] : rkey[0]);
    end
  end

  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_rnd
    aes_pkg::block_t sin, sout;
    logic            flt;
    always_comb begin
      flt = !ctl[g-1].dec &&
            ((g == NUM_ROUNDS - 2 && ctl[g-1].mode == aes_pkg::FAULT_EARLY) ||
             (g == NUM_ROUNDS - 1 && ctl[g-1].mode == aes_pkg::FAULT_LATE));
      sin = st[g-1] ^ (flt ? {ctl[g-1].fval, 120'd0} : '0);
    end
    aes_round u_rnd (
      .s      (sin),
      .rk     (ctl[g-1].dec ? rkey[NUM_ROUNDS-g] : rkey[g]),
      .dec    (ctl[g-1].dec),
      .do_mix (g != NUM_ROUNDS),
      .y      (sout)
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        st[g]  <= sout;
        ctl[g] <= ctl[g-1];
      end
    end
  end

  assign res_out.valid       = vld[NUM_ROUNDS];
  assign res_out.result_high = st[NUM_ROUNDS][127:64];
  assign res_out.result_low  = st[NUM_ROUNDS][63:0];
endmodule

// ===== design/aes_checker.sv =====
// ---------------------------------------------------------------------------
// AES port checker
// Port-level properties of the cipher block, bound to the top level.
// ---------------------------------------------------------------------------
`include "aes128_cipher_with_fault_injection_assert.svh"
module aes_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_high,
  input logic        cfg_valid
);
  `AES_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_high), "result dropped under stall")
  `AES_ASSERT_IMP(a_stall_blocks, clk, rst, out_valid && !out_ready, !in_ready, "request taken while stalled")
  `AES_ASSERT_NEXT(a_key_busy, clk, rst, cfg_valid, !in_ready, "request taken during key expansion")
endmodule

bind aes128_cipher_with_fault_injection aes_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (blk_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_high  (res_out.result_high),
  .cfg_valid (cfg.valid)
);

// ===== tb/aes128_cipher_with_fault_injection_chk.sv =====
// ---------------------------------------------------------------------------
// AES-128 result checker
// Watches the request, result and key channels, works out each expected
// block and compares results in order.
// ---------------------------------------------------------------------------
module aes128_cipher_with_fault_injection_chk (
  input  logic      clk,
  input  logic      rst,
  aes_in_if.sink    blk_mon,
  aes_out_if.sink   res_mon,
  aes_cfg_if.sink   cfg_mon,
  output int        fail_cnt,
  output int        pending,
  output int        res_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0]  key_hi, key_lo;
  logic [127:0] cipher_q[$];

  function automatic aes_pkg::byte_t dbl(aes_pkg::byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // one 128-bit block through the cipher under the current key
  function automatic logic [127:0] aes_block(aes_pkg::cmd_t c, logic [127:0] blk,
                                             aes_pkg::fault_t fm, aes_pkg::byte_t fv);
    aes_pkg::byte_t rk[0:175];
    aes_pkg::byte_t s[0:15];
    aes_pkg::byte_t t[0:15];
    aes_pkg::byte_t rc, a0, a1, a2, a3, al, u, v;
    int fr;
    logic [127:0] k, res;
    k = {key_hi, key_lo};
    for (int i = 0; i < 16; i++) begin
      rk[i] = k[127-8*i -: 8];
      s[i]  = blk[127-8*i -: 8];
    end
    rc = 8'h01;
    for (int j = 4; j < 44; j++) begin
      if (j % 4 == 0) begin
        for (int q = 0; q < 4; q++)
          rk[4*j+q] = rk[4*(j-4)+q] ^ aes_pkg::SBOX_FWD[rk[4*(j-1)+((q+1)%4)]];
        rk[4*j] ^= rc;
        rc = dbl(rc);
      end else begin
        for (int q = 0; q < 4; q++) rk[4*j+q] = rk[4*(j-4)+q] ^ rk[4*(j-1)+q];
      end
    end
    fr = (fm == aes_pkg::FAULT_EARLY) ? 8 : (fm == aes_pkg::FAULT_LATE) ? 9 : 0;
    if (c == aes_pkg::CMD_ENC) begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
        if (r == fr) s[0] ^= fv;
        for (int i = 0; i < 16; i++) t[i] = aes_pkg::SBOX_FWD[s[i]];
        for (int cc = 0; cc < 4; cc++)
          for (int rr = 0; rr < 4; rr++) s[cc*4+rr] = t[((cc+rr)%4)*4+rr];
        if (r < 10)
          for (int cc = 0; cc < 4; cc++) begin
            a0 = s[4*cc]; a1 = s[4*cc+1]; a2 = s[4*cc+2]; a3 = s[4*cc+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            s[4*cc]   = a0 ^ al ^ dbl(a0 ^ a1);
            s[4*cc+1] = a1 ^ al ^ dbl(a1 ^ a2);
            s[4*cc+2] = a2 ^ al ^ dbl(a2 ^ a3);
            s[4*cc+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        for (int i = 0; i < 16; i++) s[i] ^= rk[16*r+i];
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[160+i];
      for (int r = 9; r >= 0; r--) begin
        for (int cc = 0; cc < 4; cc++)
          for (int rr = 0; rr < 4; rr++) t[cc*4+rr] = s[((cc+4-rr)%4)*4+rr];
        for (int i = 0; i < 16; i++) s[i] = aes_pkg::SBOX_INV[t[i]] ^ rk[16*r+i];
        if (r > 0)
          for (int cc = 0; cc < 4; cc++) begin
            u = dbl(dbl(s[4*cc] ^ s[4*cc+2]));
            v = dbl(dbl(s[4*cc+1] ^ s[4*cc+3]));
            a0 = s[4*cc] ^ u; a1 = s[4*cc+1] ^ v; a2 = s[4*cc+2] ^ u; a3 = s[4*cc+3] ^ v;
            al = a0 ^ a1 ^ a2 ^ a3;
            s[4*cc]   = a0 ^ al ^ dbl(a0 ^ a1);
            s[4*cc+1] = a1 ^ al ^ dbl(a1 ^ a2);
            s[4*cc+2] = a2 ^ al ^ dbl(a2 ^ a3);
            s[4*cc+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0t: %s got %h want %h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  assign pending = cipher_q.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst) begin
      key_hi = '0;
      key_lo = '0;
      cipher_q.delete();
      fail_cnt = 0;
      res_cnt = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        res_cnt++;
        if (cipher_q.size() == 0) begin
          $display("unexpected result %0t: %h_%h", $realtime,
                   res_mon.result_high, res_mon.result_low);
          fail_cnt++;
        end else begin
          want = cipher_q.pop_front();
          if (res_mon.result_high !== want[127:64])
            report("result_high", res_mon.result_high, want[127:64]);
          if (res_mon.result_low !== want[63:0])
            report("result_low", res_mon.result_low, want[63:0]);
        end
      end
      if (blk_mon.valid && blk_mon.ready)
        cipher_q.push_back(aes_block(aes_pkg::cmd_t'(blk_mon.cmd),
                                     {blk_mon.block_high, blk_mon.block_low},
                                     aes_pkg::fault_t'(blk_mon.fault_mode),
                                     blk_mon.fault_value));
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == aes_pkg::KEY_HIGH_IDX) key_hi = cfg_mon.data;
        else if (cfg_mon.index == aes_pkg::KEY_LOW_IDX) key_lo = cfg_mon.data;
      end
    end
  end
endmodule

// ===== tb/aes128_cipher_with_fault_injection_tb.sv =====
// ---------------------------------------------------------------------------
// AES-128 cipher testbench
// Drives directed and random requests under several keys with random gaps
// and result stalls; a separate checker predicts and compares each block.
// ---------------------------------------------------------------------------
module aes128_cipher_with_fault_injection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int Latency    = 11;

  logic clk;
  logic rst;
  int   fail_cnt, pending, res_cnt, cycles;
  int   enc_cnt, dec_cnt, fault_cnt;
  bit   stall_on;

  aes_in_if  blk (clk);
  aes_out_if res (clk);
  aes_cfg_if cfg (clk);

  aes128_cipher_with_fault_injection DUT (
    .clk(clk), .rst(rst), .blk_in(blk.sink), .res_out(res.source), .cfg(cfg.sink)
  );

  aes128_cipher_with_fault_injection_chk u_chk (
    .clk(clk), .rst(rst), .blk_mon(blk.sink), .res_mon(res.sink), .cfg_mon(cfg.sink),
    .fail_cnt(fail_cnt), .pending(pending), .res_cnt(res_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall: phases with and without back-pressure
  initial begin
    int g;
    res.ready = 1'b0;
    stall_on = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(199) == 0) stall_on = ~stall_on;
      if (!stall_on) res.ready <= 1'b1;
      else begin
        g = gap_len();
        if (g == 0) res.ready <= 1'b1;
        else begin
          res.ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // leaves valid high; the caller drops it after the last write
  task automatic key_write(logic idx, logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // one request; sender gap comes first so valid never drops between back-to-back ones
  task automatic send_request(aes_pkg::cmd_t c, logic [63:0] bh, logic [63:0] bl,
                              aes_pkg::fault_t fm, aes_pkg::byte_t fv, bit with_gap);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      blk.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    blk.valid       <= 1'b1;
    blk.cmd         <= c;
    blk.block_high  <= bh;
    blk.block_low   <= bl;
    blk.fault_mode  <= fm;
    blk.fault_value <= fv;
    @(posedge clk);
    while (!blk.ready) @(posedge clk);
    @(negedge clk);
    if (c == aes_pkg::CMD_ENC) enc_cnt++; else dec_cnt++;
    if (c == aes_pkg::CMD_ENC && fm inside {aes_pkg::FAULT_EARLY, aes_pkg::FAULT_LATE} &&
        fv != 0) fault_cnt++;
  endtask

  // drain, let the pipe settle, then load a new key
  task automatic new_key(logic [63:0] kh, logic [63:0] kl);
    blk.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
    key_write(aes_pkg::KEY_HIGH_IDX, kh);
    key_write(aes_pkg::KEY_LOW_IDX, kl);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    aes_pkg::cmd_t   c;
    aes_pkg::fault_t fm;
    bit              burst;
    for (int i = 0; i < n; i++) begin
      c  = aes_pkg::cmd_t'($urandom_range(1));
      fm = aes_pkg::fault_t'($urandom_range(3));
      burst = ($urandom_range(3) == 0);
      send_request(c, rnd64(), rnd64(), fm, aes_pkg::byte_t'($urandom_range(255)), !burst);
    end
  endtask

  initial begin
    logic [63:0] ph, pl;
    rst = 1'b1;
    cycles = 0;
    enc_cnt = 0; dec_cnt = 0; fault_cnt = 0;
    blk.valid = 1'b0; blk.cmd = aes_pkg::CMD_ENC; blk.block_high = '0; blk.block_low = '0;
    blk.fault_mode = aes_pkg::FAULT_NONE; blk.fault_value = '0;
    cfg.valid = 1'b0; cfg.index = 1'b0; cfg.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset key, then the standard test key
    send_request(aes_pkg::CMD_ENC, '0, '0, aes_pkg::FAULT_NONE, 8'h00, 1'b0);
    send_request(aes_pkg::CMD_DEC, '0, '0, aes_pkg::FAULT_NONE, 8'h00, 1'b0);
    new_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    ph = 64'h3243f6a8885a308d; pl = 64'h313198a2e0370734;
    send_request(aes_pkg::CMD_ENC, ph, pl, aes_pkg::FAULT_NONE, 8'h00, 1'b0);
    send_request(aes_pkg::CMD_ENC, ph, pl, aes_pkg::FAULT_EARLY, 8'h01, 1'b0);
    send_request(aes_pkg::CMD_ENC, ph, pl, aes_pkg::FAULT_LATE, 8'h80, 1'b0);
    // unused mode: no fault
    send_request(aes_pkg::CMD_ENC, ph, pl, aes_pkg::FAULT_RSVD, 8'hff, 1'b0);
    // zero fault byte
    send_request(aes_pkg::CMD_ENC, ph, pl, aes_pkg::FAULT_EARLY, 8'h00, 1'b0);
    send_request(aes_pkg::CMD_ENC, ph, pl, aes_pkg::FAULT_LATE, 8'h00, 1'b0);
    send_request(aes_pkg::CMD_DEC, 64'h3925841d02dc09fb, 64'hdc118597196a0b32,
                 aes_pkg::FAULT_NONE, 8'h00, 1'b0);
    // decrypt ignores fault
    send_request(aes_pkg::CMD_DEC, ph, pl, aes_pkg::FAULT_EARLY, 8'h5a, 1'b0);
    send_request(aes_pkg::CMD_DEC, ph, pl, aes_pkg::FAULT_LATE, 8'ha5, 1'b1);
    send_request(aes_pkg::CMD_ENC, '1, '1, aes_pkg::FAULT_LATE, 8'hff, 1'b1);
    send_request(aes_pkg::CMD_DEC, '1, '1, aes_pkg::FAULT_RSVD, 8'hff, 1'b1);
    send_request(aes_pkg::CMD_ENC, '0, '1, aes_pkg::FAULT_EARLY, 8'h7f, 1'b1);
    new_key('1, '1);
    send_request(aes_pkg::CMD_ENC, '0, '0, aes_pkg::FAULT_NONE, 8'h00, 1'b0);
    send_request(aes_pkg::CMD_DEC, '1, '1, aes_pkg::FAULT_NONE, 8'h00, 1'b0);
    send_request(aes_pkg::CMD_ENC, '1, '0, aes_pkg::FAULT_EARLY, 8'haa, 1'b0);

    // random phases, key changed between them
    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      case (ph_i)
        0: new_key('0, '0);
        1: new_key('1, '0);
        default: new_key(rnd64(), rnd64());
      endcase
      random_phase(322);
    end

    blk.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
    $display("covered %0d encrypt (%0d faulted) and %0d decrypt requests, %0d results",
             enc_cnt, fault_cnt, dec_cnt, res_cnt);
    $display("key settings: zero, test key, all ones, half ones and four random keys");
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== aes128_cipher_with_fault_injection.f =====
+incdir+design
design/aes_pkg.sv
design/aes_stream_if.sv
design/aes_round.sv
design/aes128_cipher_with_fault_injection.sv
design/aes_checker.sv
tb/aes128_cipher_with_fault_injection_chk.sv
tb/aes128_cipher_with_fault_injection_tb.sv
